@@ sv/ahfc_pkg.sv @@
// ----------------------------------------------------------------------------
// ahfc_pkg
// Shared widths, character codes, result codes and hex decoding for the
// ascii hex frame checker.
// ----------------------------------------------------------------------------
package ahfc_pkg;

    // frame geometry
    localparam int MAX_PAYLOAD = 32;
    localparam int POS_W       = $clog2(2 * MAX_PAYLOAD + 3);

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_SKIP     = CFG_IDX_W'(1);

    localparam logic [6:0] PAYLOAD_RESET   = 7'd32;
    localparam logic [7:0] ECHO_SKIP_RESET = 8'd0;

    // frame characters
    localparam logic [7:0] CH_HEADER  = 8'h3C;
    localparam logic [7:0] CH_TRAILER = 8'h3E;
    localparam logic [7:0] SUM_INIT   = 8'h00;

    // result codes
    localparam logic       KIND_DATA      = 1'b0;
    localparam logic       KIND_STATUS    = 1'b1;
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_FRAME = 2'd1;
    localparam logic [1:0] STAT_BAD_SUM   = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // hex character to nibble, anything else decodes as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

@@ sv/ahfc_if.sv @@
// ----------------------------------------------------------------------------
// ahfc channel interfaces
// Valid/ready channels for received characters, results and register writes.
// ----------------------------------------------------------------------------
interface ahfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ahfc_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output kind, output data_byte, output status,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input last, output ready);
endinterface

interface ahfc_cfg_if;
    import ahfc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/ahfc_parser.sv @@
// ----------------------------------------------------------------------------
// ahfc_parser
// Frame state and per-character decode: echo drop, header, hex data, checksum
// and trailer, with the configuration registers.
// ----------------------------------------------------------------------------
module ahfc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  ahfc_pkg::t_cfg_wr i_cfg,
    output logic              o_res_valid,
    output ahfc_pkg::t_result o_res
);
    import ahfc_pkg::*;

    logic [6:0]       r_payload,     n_payload;
    logic [7:0]       r_echo_skip,   n_echo_skip;
    logic [7:0]       r_echo_left,   n_echo_left;
    logic [POS_W-1:0] r_frame_pos,   n_frame_pos;
    logic [7:0]       r_char_sum,    n_char_sum;
    logic [3:0]       r_high_nib,    n_high_nib;
    logic             r_header_good, n_header_good;
    logic [7:0]       r_rx_cks,      n_rx_cks;

    logic [6:0]       eff_n;
    logic [POS_W-1:0] data_end;
    logic [3:0]       nib;

    // clamp payload length into 1..MAX_PAYLOAD
    always_comb begin
        if (r_payload == 7'd0) begin
            eff_n = 7'd1;
        end else if (r_payload > 7'(MAX_PAYLOAD)) begin
            eff_n = 7'(MAX_PAYLOAD);
        end else begin
            eff_n = r_payload;
        end
    end

    assign data_end = POS_W'({eff_n, 1'b0});
    assign nib      = hex_nibble(i_byte);

    // next state and result for one character
    always_comb begin
        n_payload     = r_payload;
        n_echo_skip   = r_echo_skip;
        n_echo_left   = r_echo_left;
        n_frame_pos   = r_frame_pos;
        n_char_sum    = r_char_sum;
        n_high_nib    = r_high_nib;
        n_header_good = r_header_good;
        n_rx_cks      = r_rx_cks;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_step) begin
            if (r_echo_left != 8'd0) begin
                n_echo_left = r_echo_left - 8'd1;
            end else if (r_frame_pos == '0) begin
                n_header_good = (i_byte == CH_HEADER);
                n_frame_pos   = POS_W'(1);
            end else if (r_frame_pos <= data_end) begin
                n_char_sum  = r_char_sum + i_byte;
                n_frame_pos = r_frame_pos + POS_W'(1);
                if (r_frame_pos[0]) begin
                    n_high_nib = nib;
                end else begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_DATA;
                    o_res.data_byte = {r_high_nib, nib};
                    o_res.status    = STAT_OK;
                    o_res.last      = 1'b0;
                end
            end else if (r_frame_pos == data_end + POS_W'(1)) begin
                n_rx_cks    = {nib, 4'h0};
                n_frame_pos = r_frame_pos + POS_W'(1);
            end else if (r_frame_pos == data_end + POS_W'(2)) begin
                n_rx_cks    = {r_rx_cks[7:4], nib};
                n_frame_pos = r_frame_pos + POS_W'(1);
            end else begin
                // trailer: framing errors outrank a checksum mismatch
                o_res_valid = 1'b1;
                o_res.kind  = KIND_STATUS;
                o_res.last  = 1'b1;
                if (!r_header_good || i_byte != CH_TRAILER) begin
                    o_res.status = STAT_BAD_FRAME;
                end else if (r_rx_cks != r_char_sum) begin
                    o_res.status = STAT_BAD_SUM;
                end else begin
                    o_res.status = STAT_OK;
                end
                n_echo_left   = r_echo_skip;
                n_frame_pos   = '0;
                n_char_sum    = SUM_INIT;
                n_high_nib    = 4'h0;
                n_header_good = 1'b0;
                n_rx_cks      = 8'h00;
            end
        end

        // register writes, unknown indexes are dropped
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PAYLOAD_BYTES: begin
                    n_payload = i_cfg.data[6:0];
                end
                CFG_ECHO_SKIP: begin
                    n_echo_skip = i_cfg.data;
                    if (r_frame_pos == '0) begin
                        n_echo_left = i_cfg.data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload     <= PAYLOAD_RESET;
            r_echo_skip   <= ECHO_SKIP_RESET;
            r_echo_left   <= ECHO_SKIP_RESET;
            r_frame_pos   <= '0;
            r_char_sum    <= SUM_INIT;
            r_high_nib    <= 4'h0;
            r_header_good <= 1'b0;
            r_rx_cks      <= 8'h00;
        end else begin
            r_payload     <= n_payload;
            r_echo_skip   <= n_echo_skip;
            r_echo_left   <= n_echo_left;
            r_frame_pos   <= n_frame_pos;
            r_char_sum    <= n_char_sum;
            r_high_nib    <= n_high_nib;
            r_header_good <= n_header_good;
            r_rx_cks      <= n_rx_cks;
        end
    end

endmodule

@@ sv/ascii_hex_frame_checker_unit.sv @@
// Path: an accepted character is held in the input register, and its result
// beat is then registered in the result buffer.
// Throughput: one character per cycle unless a full, stalled result buffer
// holds it; two entries let a character in while a result waits on the output.
// Reset (i_rst_n low, synchronous): registers return to payload 32, echo 0,
// frame state cleared and no beat held.
// ----------------------------------------------------------------------------
// ascii_hex_frame_checker_unit
// Top level: input register, frame parser and a two-entry result buffer.
// ----------------------------------------------------------------------------
module ascii_hex_frame_checker_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ahfc_rx_if.sink         i_rx,
    ahfc_res_if.source      o_res,
    ahfc_cfg_if.sink        i_cfg
);
    import ahfc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_result    r_out, r_skid;
    logic       r_out_valid, r_skid_valid;

    logic       pop;
    logic       advance;
    logic       rx_take;
    logic       push;
    t_result    res;
    logic       res_valid;
    t_cfg_wr    cfg;

    // stage handshakes
    assign pop     = r_out_valid && o_res.ready;
    assign advance = r_in_valid && (!r_skid_valid || pop);
    assign rx_take = i_rx.valid && i_rx.ready;
    assign push    = advance && res_valid;

    assign i_rx.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign cfg.valid = i_cfg.valid;
    assign cfg.index = i_cfg.index;
    assign cfg.data  = i_cfg.data;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    ahfc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result buffer: output register backed by a skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= push;
            end
        end else if (r_out_valid) begin
            if (pop) begin
                r_out_valid <= push;
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end else begin
            r_out_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
                if (push) begin
                    r_skid <= res;
                end
            end
        end else if (r_out_valid) begin
            if (pop && push) begin
                r_out <= res;
            end else if (push) begin
                r_skid <= res;
            end
        end else if (push) begin
            r_out <= res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_out.kind;
    assign o_res.data_byte = r_out.data_byte;
    assign o_res.status    = r_out.status;
    assign o_res.last      = r_out.last;

endmodule

@@ sv/ahfc_checker.sv @@
// ----------------------------------------------------------------------------
// ahfc_checker
// Port-level checks on the result channel of the frame checker unit.
// ----------------------------------------------------------------------------
module ahfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_kind,
    input logic [7:0] i_data_byte,
    input logic [1:0] i_status,
    input logic       i_last
);
    import ahfc_pkg::*;

    // data beats carry no status and never close a frame
    a_data_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_kind == KIND_DATA |-> i_status == STAT_OK && !i_last)
        else $error("data beat with status or last set");

    // status beats close the frame with a zero data field
    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_kind == KIND_STATUS |-> i_last && i_data_byte == 8'h00)
        else $error("status beat malformed");

    // status code stays within its defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_status == STAT_OK || i_status == STAT_BAD_FRAME ||
                        i_status == STAT_BAD_SUM)
        else $error("undefined status code");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_res_valid)
        else $error("result beat right after reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid &&
            $stable({i_kind, i_data_byte, i_status, i_last}))
        else $error("stalled result beat changed");

endmodule

bind ascii_hex_frame_checker_unit ahfc_checker u_ahfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_data_byte (o_res.data_byte),
    .i_status    (o_res.status),
    .i_last      (o_res.last)
);
